[rtl/ssmp_pkg.sv]
// ----------------------------------------------------------------------------
// ssmp_pkg
// Shared types, constants and curve tables of the servo motion profiler.
// ----------------------------------------------------------------------------
package ssmp_pkg;

	localparam int DEF_CHANNELS     = 16;
	localparam int DEF_CURVE_POINTS = 100;
	localparam int TBL_LEN          = 100;
	localparam int PERIOD_MAX       = 1023;

	// input op codes
	localparam logic [2:0] OP_TICK   = 3'd0;
	localparam logic [2:0] OP_TARGET = 3'd1;
	localparam logic [2:0] OP_ENABLE = 3'd2;
	localparam logic [2:0] OP_DIS    = 3'd3;
	localparam logic [2:0] OP_CURVE  = 3'd4;
	localparam logic [2:0] OP_QUERY  = 3'd5;

	// curve kinds
	localparam logic [1:0] CK_SCURVE = 2'd0;
	localparam logic [1:0] CK_LINEAR = 2'd1;
	localparam logic [1:0] CK_STEP   = 2'd2;

	// per-channel motion states
	localparam logic [3:0] M_RESET           = 4'd0;
	localparam logic [3:0] M_ENABLED         = 4'd1;
	localparam logic [3:0] M_STOPPED         = 4'd2;
	localparam logic [3:0] M_STOP_PEND       = 4'd3;
	localparam logic [3:0] M_STOP_PEND_DIS   = 4'd4;
	localparam logic [3:0] M_MOVING          = 4'd5;
	localparam logic [3:0] M_MOVING_DIS      = 4'd6;
	localparam logic [3:0] M_MOVING_PEND     = 4'd7;
	localparam logic [3:0] M_MOVING_PEND_DIS = 4'd8;
	localparam logic [3:0] M_DISABLED        = 4'd9;

	typedef logic signed [12:0] pos_t;

	typedef struct packed {
		logic        start;
		logic        half;     // 16-bit dividend, 16 steps
		logic [31:0] dividend;
		logic [9:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quotient;
	} div_rsp_t;

	localparam logic [8:0] TBL_S [TBL_LEN] = '{
		9'd0,9'd0,9'd0,9'd0,9'd0,9'd0,9'd0,9'd1,9'd1,9'd1,9'd2,9'd2,9'd3,9'd4,9'd4,
		9'd5,9'd7,9'd8,9'd9,9'd11,9'd12,9'd14,9'd16,9'd18,9'd21,9'd23,9'd26,9'd29,
		9'd32,9'd35,9'd38,9'd41,9'd45,9'd49,9'd53,9'd57,9'd61,9'd65,9'd69,9'd74,
		9'd78,9'd83,9'd88,9'd93,9'd98,9'd103,9'd108,9'd113,9'd118,9'd123,9'd128,
		9'd133,9'd138,9'd143,9'd148,9'd153,9'd158,9'd163,9'd168,9'd173,9'd178,
		9'd182,9'd187,9'd191,9'd195,9'd199,9'd203,9'd207,9'd211,9'd215,9'd218,
		9'd221,9'd224,9'd227,9'd230,9'd233,9'd235,9'd238,9'd240,9'd242,9'd244,
		9'd245,9'd247,9'd248,9'd249,9'd251,9'd252,9'd252,9'd253,9'd254,9'd254,
		9'd255,9'd255,9'd255,9'd256,9'd256,9'd256,9'd256,9'd256,9'd256};

	localparam logic [8:0] TBL_LIN [TBL_LEN] = '{
		9'd0,9'd2,9'd5,9'd7,9'd10,9'd12,9'd15,9'd18,9'd20,9'd23,9'd25,9'd28,9'd31,
		9'd33,9'd36,9'd38,9'd41,9'd43,9'd46,9'd49,9'd51,9'd54,9'd56,9'd59,9'd62,
		9'd64,9'd67,9'd69,9'd72,9'd74,9'd77,9'd80,9'd82,9'd85,9'd87,9'd90,9'd93,
		9'd95,9'd98,9'd100,9'd103,9'd106,9'd108,9'd111,9'd113,9'd116,9'd118,9'd121,
		9'd124,9'd126,9'd129,9'd131,9'd134,9'd137,9'd139,9'd142,9'd144,9'd147,
		9'd149,9'd152,9'd155,9'd157,9'd160,9'd162,9'd165,9'd168,9'd170,9'd173,
		9'd175,9'd178,9'd181,9'd183,9'd186,9'd188,9'd191,9'd193,9'd196,9'd199,
		9'd201,9'd204,9'd206,9'd209,9'd212,9'd214,9'd217,9'd219,9'd222,9'd224,
		9'd227,9'd230,9'd232,9'd235,9'd237,9'd240,9'd243,9'd245,9'd248,9'd250,
		9'd253,9'd256};

	function automatic logic [8:0] curve_at(logic [1:0] sel, logic [6:0] t);
		logic [8:0] v;
		if (sel == CK_STEP)
			v = 9'd256;
		else if (sel == CK_SCURVE)
			v = TBL_S[t];
		else
			v = TBL_LIN[t];
		return v;
	endfunction

endpackage

[rtl/ssmp_in_if.sv]
// ----------------------------------------------------------------------------
// ssmp_in_if
// Command word channel of the servo motion profiler.
// ----------------------------------------------------------------------------
interface ssmp_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic [3:0]  channel;
	logic [11:0] target_pulse;
	logic [15:0] duration_ms;
	logic [1:0]  curve_kind;
	logic [31:0] now_ms;

	modport source (output valid, op, channel, target_pulse, duration_ms, curve_kind,
		now_ms, input ready);
	modport sink (input valid, op, channel, target_pulse, duration_ms, curve_kind,
		now_ms, output ready);
endinterface

[rtl/ssmp_out_if.sv]
// ----------------------------------------------------------------------------
// ssmp_out_if
// Result word channel of the servo motion profiler.
// ----------------------------------------------------------------------------
interface ssmp_out_if;
	logic               valid;
	logic               ready;
	logic [3:0]         out_channel;
	logic [15:0]        pulse_word;
	logic               write_needed;
	logic [4:0]         active_count;
	logic               accepted;
	logic               is_changing;
	logic signed [12:0] position;
	logic               last;

	modport source (output valid, out_channel, pulse_word, write_needed, active_count,
		accepted, is_changing, position, last, input ready);
	modport sink (input valid, out_channel, pulse_word, write_needed, active_count,
		accepted, is_changing, position, last, output ready);
endinterface

[rtl/ssmp_div.sv]
// ----------------------------------------------------------------------------
// ssmp_div
// Restoring divider, one quotient bit a cycle, 32 or 16 steps.
// ----------------------------------------------------------------------------
module ssmp_div (
	input  logic              clk,
	input  logic              arst_n,
	input  ssmp_pkg::div_req_t req,
	output ssmp_pkg::div_rsp_t rsp
);
	import ssmp_pkg::*;

	logic        busy_q, done_q;
	logic [5:0]  cnt_q;
	logic [9:0]  rem_q, dsr_q;
	logic [31:0] quo_q;
	logic [10:0] rem_sh;
	logic        ge;

	assign rem_sh = {rem_q, quo_q[31]};
	assign ge     = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= req.half ? 6'd16 : 6'd32;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dsr_q <= req.divisor;
			quo_q <= req.half ? {req.dividend[15:0], 16'd0} : req.dividend;
		end else if (busy_q) begin
			rem_q <= ge ? 10'(rem_sh - {1'b0, dsr_q}) : rem_sh[9:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;
endmodule

[rtl/servo_scurve_motion_profiler_core.sv]
// ----------------------------------------------------------------------------
// servo_scurve_motion_profiler_core
// Multi-channel servo motion profiler with table-based S-curve and linear interpolation.
// ----------------------------------------------------------------------------
// One command word is taken at a time; ready stays low until it is finished.
// Set target takes its step period from a reciprocal multiplication; enable
// and query wait while an earlier result word still waits; disable and select
// curve do not wait. A tick visits each channel in turn through the single
// shared divider: an idle channel is only visited, a moving one goes through
// visit, launch, the 32-step time division, table lookup and update while
// still mid-move, and skips lookup and update on the step that finishes it.
// A tick then sends one result word per channel, each waiting while the result
// side is not ready. No clearing pass after reset.
module servo_scurve_motion_profiler_core #(
	parameter int CHANNELS     = ssmp_pkg::DEF_CHANNELS,
	parameter int CURVE_POINTS = ssmp_pkg::DEF_CURVE_POINTS
) (
	input  logic       clk,
	input  logic       arst_n,
	ssmp_in_if.sink    item,
	ssmp_out_if.source res
);
	import ssmp_pkg::*;

	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int IW = $clog2(CHANNELS + 1);

	// reciprocals for the divisions by CURVE_POINTS (exact over their ranges)
	localparam int LG = $clog2(CURVE_POINTS);
	localparam int KI = 15 + LG;
	localparam int KD = 16 + LG;
	localparam logic [17:0] MI = 18'((2 ** KI + CURVE_POINTS - 1) / CURVE_POINTS);
	localparam logic [17:0] MD = 18'((2 ** KD + CURVE_POINTS - 1) / CURVE_POINTS);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DISP  = 4'd1;
	localparam logic [3:0] ST_SETW  = 4'd2;
	localparam logic [3:0] ST_VISIT = 4'd3;
	localparam logic [3:0] ST_D1GO  = 4'd4;
	localparam logic [3:0] ST_D1W   = 4'd5;
	localparam logic [3:0] ST_LOOK  = 4'd6;
	localparam logic [3:0] ST_UPD   = 4'd7;
	localparam logic [3:0] ST_EMIT  = 4'd8;

	logic [3:0]  ms_q     [CHANNELS];
	pos_t        start_q  [CHANNELS];
	pos_t        end_q    [CHANNELS];
	pos_t        cur_q    [CHANNELS];
	logic [31:0] mst_q    [CHANNELS];
	logic [9:0]  sp_q     [CHANNELS];
	logic [1:0]  sel_q    [CHANNELS];
	pos_t        pend_q   [CHANNELS];
	logic [9:0]  pper_q   [CHANNELS];
	logic [15:0] shadow_q [CHANNELS];
	logic signed [13:0] delta_q [CHANNELS];

	logic [3:0]  st_q;
	logic [CW-1:0] ch_q;
	logic [3:0]  chn_q;
	logic [2:0]  op_q;
	logic [11:0] tp_q;
	logic [15:0] dur_q;
	logic [1:0]  kind_q;
	logic [31:0] now_q;
	logic [IW-1:0] inact_q;
	logic        chg_q;
	logic signed [23:0] prod_q;
	logic [6:0]  tix_q;

	logic        ov_q;
	logic [3:0]  o_ch_q;
	logic [15:0] o_pw_q;
	logic        o_wn_q, o_acc_q, o_chg_q, o_last_q;
	logic [4:0]  o_act_q;
	pos_t        o_pos_q;

	div_req_t dreq;
	div_rsp_t drsp;

	ssmp_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// current channel views
	logic [3:0]  s_cur;
	pos_t        cur_pos, end_pos, pend_pos, new_pos, start_pos;
	logic [9:0]  per;
	logic        out_free, load_o, idx_end, ch_last;
	logic [6:0]  t_idx;
	logic [8:0]  cv;
	logic signed [16:0] sum;
	logic [15:0] new_word;
	logic [9:0]  per_sat;
	logic [14:0] tix_num;
	logic [32:0] tix_prod;
	logic [33:0] per_prod;
	logic [15:0] per_quo;

	assign s_cur     = ms_q[ch_q];
	assign cur_pos   = cur_q[ch_q];
	assign end_pos   = end_q[ch_q];
	assign pend_pos  = pend_q[ch_q];
	assign start_pos = start_q[ch_q];
	assign per       = (sp_q[ch_q] == 10'd0) ? 10'd1 : sp_q[ch_q];
	assign out_free  = !ov_q || res.ready;
	assign load_o    = out_free && (st_q == ST_EMIT || (st_q == ST_DISP &&
		(op_q == OP_ENABLE || op_q == OP_QUERY) && 32'(chn_q) < 32'(CHANNELS)));
	assign idx_end   = drsp.quotient >= 32'(CURVE_POINTS - 1);
	assign ch_last   = ch_q == CW'(CHANNELS - 1);
	// table index = step index * TBL_LEN / CURVE_POINTS
	assign tix_num   = 15'(drsp.quotient[7:0]) * 15'(TBL_LEN);
	assign tix_prod  = 33'(tix_num) * 33'(MI);
	assign t_idx     = (tix_q >= 7'(TBL_LEN - 1)) ? 7'(TBL_LEN - 1) : tix_q;
	assign cv        = curve_at(sel_q[ch_q], t_idx);
	assign sum       = 17'(start_pos) + 17'(prod_q >>> 8);
	// step period = duration / CURVE_POINTS, saturated
	assign per_prod  = 34'(dur_q) * 34'(MD);
	assign per_quo   = 16'(per_prod >> KD);
	assign per_sat   = (per_quo > 16'(PERIOD_MAX)) ? 10'(PERIOD_MAX) : per_quo[9:0];

	always_comb begin
		if (st_q == ST_UPD) begin
			if (sum > 17'sd4095)
				new_pos = 13'sd4095;
			else if (sum < -17'sd4096)
				new_pos = -13'sd4096;
			else
				new_pos = sum[12:0];
		end else begin
			new_pos = end_pos;
		end
		new_word = {{3{new_pos[12]}}, new_pos};
	end

	always_comb begin
		dreq = '0;
		unique case (st_q)
			ST_D1GO: begin
				dreq.start    = 1'b1;
				dreq.dividend = now_q - mst_q[ch_q];
				dreq.divisor  = per;
			end
			default: dreq = '0;
		endcase
	end

	assign item.ready = st_q == ST_IDLE;

	// sequencer and channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			ch_q    <= '0;
			inact_q <= '0;
			chg_q   <= 1'b0;
			ov_q    <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				ms_q[i]     <= M_RESET;
				start_q[i]  <= -13'sd1;
				end_q[i]    <= -13'sd1;
				cur_q[i]    <= -13'sd1;
				mst_q[i]    <= '1;
				sp_q[i]     <= '0;
				sel_q[i]    <= CK_SCURVE;
				pend_q[i]   <= -13'sd1;
				pper_q[i]   <= '0;
				shadow_q[i] <= '0;
				delta_q[i]  <= '0;
			end
		end else begin
			ov_q <= load_o || (ov_q && !res.ready);
			unique case (st_q)
				ST_IDLE: begin
					if (item.valid) begin
						ch_q <= CW'(item.channel);
						st_q <= ST_DISP;
					end
				end
				ST_DISP: begin
					if (op_q == OP_TICK) begin
						ch_q    <= '0;
						inact_q <= '0;
						chg_q   <= 1'b0;
						st_q    <= ST_VISIT;
					end else if (op_q > OP_QUERY || 32'(chn_q) >= 32'(CHANNELS)) begin
						st_q <= ST_IDLE;
					end else begin
						priority case (op_q)
							OP_TARGET: st_q <= ST_SETW;
							OP_ENABLE, OP_QUERY: begin
								if (out_free) begin
									if (op_q == OP_ENABLE &&
										(s_cur == M_DISABLED || s_cur == M_RESET))
										ms_q[ch_q] <= M_ENABLED;
									st_q <= ST_IDLE;
								end
							end
							OP_DIS: begin
								if (s_cur == M_MOVING)
									ms_q[ch_q] <= M_MOVING_DIS;
								else if (s_cur == M_MOVING_PEND)
									ms_q[ch_q] <= M_MOVING_PEND_DIS;
								else if (s_cur == M_STOP_PEND)
									ms_q[ch_q] <= M_STOP_PEND_DIS;
								else if (s_cur == M_RESET || s_cur == M_ENABLED ||
									s_cur == M_STOPPED)
									ms_q[ch_q] <= M_DISABLED;
								st_q <= ST_IDLE;
							end
							default: begin
								if (kind_q == CK_SCURVE)
									sel_q[ch_q] <= CK_SCURVE;
								else if (kind_q == CK_STEP) begin
									sel_q[ch_q]   <= CK_STEP;
									start_q[ch_q] <= '0;
								end else
									sel_q[ch_q] <= CK_LINEAR;
								st_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_SETW: begin
					st_q <= ST_IDLE;
					if (end_pos == pos_t'({1'b0, tp_q})) begin
						if (s_cur == M_ENABLED)
							ms_q[ch_q] <= M_STOPPED;
					end else if (s_cur == M_ENABLED) begin
						ms_q[ch_q]   <= M_STOP_PEND;
						pend_q[ch_q] <= pos_t'({1'b0, tp_q});
						pper_q[ch_q] <= '0;
					end else if (s_cur == M_STOPPED || s_cur == M_STOP_PEND ||
						s_cur == M_MOVING || s_cur == M_MOVING_PEND) begin
						if (s_cur == M_STOPPED || s_cur == M_STOP_PEND ||
							(s_cur == M_MOVING && sel_q[ch_q] != CK_SCURVE))
							ms_q[ch_q] <= M_STOP_PEND;
						else
							ms_q[ch_q] <= M_MOVING_PEND;
						pend_q[ch_q] <= pos_t'({1'b0, tp_q});
						pper_q[ch_q] <= per_sat;
					end
				end
				ST_VISIT: begin
					if (s_cur == M_RESET || s_cur == M_DISABLED) begin
						inact_q <= inact_q + IW'(1);
						st_q    <= ch_last ? ST_EMIT : ST_VISIT;
						ch_q    <= ch_last ? '0 : ch_q + CW'(1);
					end else if (s_cur == M_STOP_PEND || s_cur == M_STOP_PEND_DIS) begin
						// load the pending move
						start_q[ch_q] <= cur_pos;
						end_q[ch_q]   <= pend_pos;
						delta_q[ch_q] <= 14'(pend_pos) - 14'(cur_pos);
						pend_q[ch_q]  <= -13'sd1;
						pper_q[ch_q]  <= '0;
						if (pend_pos == cur_pos) begin
							ms_q[ch_q] <= (s_cur == M_STOP_PEND) ? M_STOPPED : M_DISABLED;
							sp_q[ch_q] <= pper_q[ch_q];
							mst_q[ch_q] <= now_q;
							st_q <= ch_last ? ST_EMIT : ST_VISIT;
							ch_q <= ch_last ? '0 : ch_q + CW'(1);
						end else begin
							ms_q[ch_q] <= (s_cur == M_STOP_PEND) ? M_MOVING : M_MOVING_DIS;
							if (pper_q[ch_q] == 10'd0) begin
								sp_q[ch_q]  <= 10'd1;
								mst_q[ch_q] <= now_q - 32'(CURVE_POINTS);
							end else begin
								sp_q[ch_q]  <= pper_q[ch_q];
								mst_q[ch_q] <= now_q;
							end
							st_q <= ST_D1GO;
						end
					end else if (s_cur == M_MOVING || s_cur == M_MOVING_DIS ||
						s_cur == M_MOVING_PEND || s_cur == M_MOVING_PEND_DIS) begin
						st_q <= ST_D1GO;
					end else begin
						st_q <= ch_last ? ST_EMIT : ST_VISIT;
						ch_q <= ch_last ? '0 : ch_q + CW'(1);
					end
				end
				ST_D1GO: st_q <= ST_D1W;
				ST_D1W: begin
					if (drsp.done) begin
						if (idx_end) begin
							// move finished: land exactly on the end value
							cur_q[ch_q] <= new_pos;
							if (s_cur == M_MOVING)
								ms_q[ch_q] <= M_STOPPED;
							else if (s_cur == M_MOVING_PEND)
								ms_q[ch_q] <= M_STOP_PEND;
							else if (s_cur == M_MOVING_DIS)
								ms_q[ch_q] <= M_DISABLED;
							else if (s_cur == M_MOVING_PEND_DIS)
								ms_q[ch_q] <= M_STOP_PEND_DIS;
							if (new_word != shadow_q[ch_q]) begin
								shadow_q[ch_q] <= new_word;
								chg_q <= 1'b1;
							end
							st_q <= ch_last ? ST_EMIT : ST_VISIT;
							ch_q <= ch_last ? '0 : ch_q + CW'(1);
						end else begin
							st_q <= ST_LOOK;
						end
					end
				end
				ST_LOOK: st_q <= ST_UPD;
				ST_UPD: begin
					cur_q[ch_q] <= new_pos;
					if (new_word != shadow_q[ch_q]) begin
						shadow_q[ch_q] <= new_word;
						chg_q <= 1'b1;
					end
					st_q <= ch_last ? ST_EMIT : ST_VISIT;
					ch_q <= ch_last ? '0 : ch_q + CW'(1);
				end
				ST_EMIT: begin
					if (out_free) begin
						if (ch_last)
							st_q <= ST_IDLE;
						else
							ch_q <= ch_q + CW'(1);
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// captured word and datapath registers
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			op_q   <= item.op;
			chn_q  <= item.channel;
			tp_q   <= item.target_pulse;
			dur_q  <= item.duration_ms;
			kind_q <= item.curve_kind;
			now_q  <= item.now_ms;
		end
		if (st_q == ST_D1W && drsp.done)
			tix_q <= 7'(tix_prod >> KI);
		if (st_q == ST_LOOK)
			prod_q <= 24'(signed'({1'b0, cv}) * delta_q[ch_q]);
	end

	// result register
	always_ff @(posedge clk) begin
		if (load_o) begin
			o_ch_q  <= 4'(ch_q);
			o_pw_q  <= shadow_q[ch_q];
			o_wn_q  <= (st_q == ST_EMIT) ? chg_q : 1'b0;
			o_act_q <= (st_q == ST_EMIT) ? 5'(CHANNELS - int'(inact_q)) : 5'd0;
			o_acc_q <= st_q == ST_DISP && op_q == OP_ENABLE &&
				(s_cur == M_DISABLED || s_cur == M_RESET);
			o_chg_q <= st_q == ST_DISP && op_q == OP_QUERY &&
				(s_cur == M_MOVING || s_cur == M_MOVING_DIS ||
				s_cur == M_MOVING_PEND || s_cur == M_MOVING_PEND_DIS ||
				s_cur == M_STOP_PEND || s_cur == M_STOP_PEND_DIS);
			o_pos_q <= (st_q == ST_DISP && op_q == OP_QUERY) ? cur_pos : '0;
			o_last_q <= (st_q == ST_EMIT) ? ch_last : 1'b1;
		end
	end

	assign res.valid        = ov_q;
	assign res.out_channel  = o_ch_q;
	assign res.pulse_word   = o_pw_q;
	assign res.write_needed = o_wn_q;
	assign res.active_count = o_act_q;
	assign res.accepted     = o_acc_q;
	assign res.is_changing  = o_chg_q;
	assign res.position     = o_pos_q;
	assign res.last         = o_last_q;

	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !item.ready)
		else $error("second word taken while busy");

	a_inact_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(inact_q) <= 32'(CHANNELS))
		else $error("inactive count beyond channel count");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_IDLE |-> !dreq.start)
		else $error("divider started while idle");

	a_emit_last: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_EMIT && out_free && ch_last |=> st_q == ST_IDLE && ov_q)
		else $error("tick results not closed by last word");
endmodule
